FILE: hw/rtl/bce_pkg.sv
// Package for the block cipher encrypt core: request/response types, S-box and round functions.
`default_nettype none

package bce_pkg;

	// Default number of rounds (AES-128)
	localparam int ROUNDS_DEF = 10;

	// Fixed field widths
	localparam int KEY_SLOT_W = 4;
	localparam int HALF_W     = 64;
	localparam int BLOCK_W    = 2 * HALF_W;

	// Opcodes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	// GF(2^8) reduction polynomial (low byte)
	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef struct packed {
		logic                  opcode;
		logic [KEY_SLOT_W-1:0] key_slot;
		logic [HALF_W-1:0]     block_high;
		logic [HALF_W-1:0]     block_low;
	} req_t;

	typedef struct packed {
		logic [HALF_W-1:0] cipher_high;
		logic [HALF_W-1:0] cipher_low;
	} rsp_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	// Byte substitution followed by row shift; byte 0 sits in the top bits
	function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[s[BLOCK_W-1-8*(4*((c+r)%4)+r) -: 8]];
			end
		end
		return o;
	endfunction

	// Column mix over the four columns
	function automatic logic [BLOCK_W-1:0] col_mix(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] o;
		logic [7:0] s0, s1, s2, s3, all;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			s0  = s[BLOCK_W-1-8*(4*c)   -: 8];
			s1  = s[BLOCK_W-1-8*(4*c+1) -: 8];
			s2  = s[BLOCK_W-1-8*(4*c+2) -: 8];
			s3  = s[BLOCK_W-1-8*(4*c+3) -: 8];
			all = s0 ^ s1 ^ s2 ^ s3;
			o[BLOCK_W-1-8*(4*c)   -: 8] = s0 ^ all ^ xtime(s0 ^ s1);
			o[BLOCK_W-1-8*(4*c+1) -: 8] = s1 ^ all ^ xtime(s1 ^ s2);
			o[BLOCK_W-1-8*(4*c+2) -: 8] = s2 ^ all ^ xtime(s2 ^ s3);
			o[BLOCK_W-1-8*(4*c+3) -: 8] = s3 ^ all ^ xtime(s3 ^ s0);
		end
		return o;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bce_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/block_cipher_encrypt.sv
// Top level of the block cipher encrypt core: round-key memory, round sequencer, result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------
//  req     | in        | req_valid / req_ready | bce_pkg::req_t (load/enc)
//  rsp     | out       | rsp_valid / rsp_ready | bce_pkg::rsp_t (cipher)
//
// A key load gives no response.
// An encrypt request occupies the round unit from acceptance through its final round:
// the accept cycle issues the read of key 0, then the keys in the RAM are read in order,
// paced by the single registered read port of the round-key memory.
// Reset clears the sequencer and response valid; key RAM contents are undefined until loaded.
// A waiting response does not block the next request; the final round holds only if the
// response register is still full when that round completes.
`default_nettype none

module block_cipher_encrypt #(
	parameter int ROUNDS = bce_pkg::ROUNDS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bce_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bce_pkg::rsp_t      rsp
);

	localparam int SLOTS = ROUNDS + 1;
	localparam int IW    = $clog2(SLOTS);
	localparam logic [bce_pkg::KEY_SLOT_W-1:0] SLOTS_K = bce_pkg::KEY_SLOT_W'(SLOTS);
	localparam logic [IW-1:0] LAST_RND = IW'(ROUNDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                    state_q;
	logic [IW-1:0]                 rnd_q;
	logic [bce_pkg::BLOCK_W-1:0]   st_q;
	logic                          rsp_valid_q;
	bce_pkg::rsp_t                 rsp_q;

	logic                          req_fire;
	logic                          out_free;
	logic                          wr_en;
	logic                          rd_en;
	logic [IW-1:0]                 rd_addr;
	logic [bce_pkg::BLOCK_W-1:0]   key;
	logic [bce_pkg::BLOCK_W-1:0]   ss;
	logic [bce_pkg::BLOCK_W-1:0]   rnd_out;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Key RAM access; loads happen only while idle, reads only for an encrypt in flight,
	// so the two ports never touch the same entry in overlapping cycles
	assign wr_en   = req_fire && (req.opcode == bce_pkg::OP_LOAD) && (req.key_slot < SLOTS_K);
	assign rd_en   = (req_fire && (req.opcode == bce_pkg::OP_ENCRYPT)) ||
	                 ((state_q == ST_RUN) && (rnd_q != LAST_RND));
	assign rd_addr = (state_q == ST_RUN) ? IW'(rnd_q + 1'b1) : '0;

	bce_ram #(
		.WIDTH (bce_pkg::BLOCK_W),
		.DEPTH (SLOTS)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (req.key_slot[IW-1:0]),
		.wr_data ({req.block_high, req.block_low}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (key)
	);

	// Shared round unit: initial key add, full round, or final round
	always_comb begin
		ss = bce_pkg::sub_shift(st_q);
		if (rnd_q == '0) begin
			rnd_out = st_q ^ key;
		end else if (rnd_q == LAST_RND) begin
			rnd_out = ss ^ key;
		end else begin
			rnd_out = bce_pkg::col_mix(ss) ^ key;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.opcode == bce_pkg::OP_ENCRYPT)) begin
						state_q <= ST_RUN;
						rnd_q   <= '0;
					end
				end
				ST_RUN: begin
					if (rnd_q == LAST_RND) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end else begin
						rnd_q <= IW'(rnd_q + 1'b1);
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Cipher state register
	always_ff @(posedge clk) begin
		if (req_fire) begin
			st_q <= {req.block_high, req.block_low};
		end else if (state_q == ST_RUN) begin
			st_q <= rnd_out;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_RUN) && (rnd_q == LAST_RND) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if ((state_q == ST_HOLD) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && (rnd_q == LAST_RND) && out_free) begin
			rsp_q <= rnd_out;
		end else if ((state_q == ST_HOLD) && out_free) begin
			rsp_q <= st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// Round counter never passes the last key
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rnd_q <= LAST_RND))
		else $error("round counter out of range");

	// An accepted encrypt starts at the initial key add
	a_enc_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.opcode == bce_pkg::OP_ENCRYPT)) |=>
		((state_q == ST_RUN) && (rnd_q == '0)))
		else $error("encrypt did not start at round zero");

	// A response appears only out of the final round or the hold state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> (($past(state_q) == ST_RUN) || ($past(state_q) == ST_HOLD)))
		else $error("response raised without a finished block");

	// Key loads never overlap an encrypt in flight
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("key write while busy");
`endif

endmodule

`default_nettype wire

FILE: sim/block_cipher_encrypt_checker.sv
// Checker for the block cipher encrypt core: watches both channels, predicts ciphertext, compares.
`timescale 1ns / 1ps

module block_cipher_encrypt_checker #(
	parameter int ROUNDS = bce_pkg::ROUNDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  bce_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  bce_pkg::rsp_t rsp,
	output int            mismatch_count,
	output int            pending_count
);

	localparam logic [7:0] FIELD_POLY   = 8'h1b;
	localparam logic [7:0] AFFINE_CONST = 8'h63;
	localparam int         REPORT_LIMIT = 10;

	logic [7:0]   sbox_lut [256];
	logic [127:0] key_store [ROUNDS+1];
	logic [127:0] cipher_q [$];
	logic [127:0] want;
	int           errors = 0;

	// GF(2^8) product, shift-and-add
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY : 8'h00);
		end
		return p;
	endfunction

	// S-box built from the field inverse and the affine map, not from a table
	initial begin
		logic [7:0] inv, sq, b;
		for (int x = 0; x < 256; x++) begin
			// inverse as x^254; zero maps to zero
			sq  = 8'(x);
			inv = 8'h01;
			for (int k = 0; k < 7; k++) begin
				sq  = gf_mul(sq, sq);
				inv = gf_mul(inv, sq);
			end
			b = inv;
			sbox_lut[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ AFFINE_CONST;
		end
	end

	// Full cipher over the locally held round keys
	function automatic logic [127:0] predict_cipher(input logic [127:0] plain);
		logic [7:0]   st [16];
		logic [7:0]   sub [16];
		logic [7:0]   a0, a1, a2, a3;
		logic [127:0] key, result;
		for (int i = 0; i < 16; i++) st[i] = plain[127-8*i -: 8];
		for (int r = 0; r <= ROUNDS; r++) begin
			if (r > 0) begin
				// substitute, then rotate row w left by w columns
				for (int i = 0; i < 16; i++) sub[i] = sbox_lut[st[i]];
				for (int c = 0; c < 4; c++) begin
					for (int w = 0; w < 4; w++) st[4*c+w] = sub[4*((c+w)%4)+w];
				end
				// column mix skipped in the last round
				if (r < ROUNDS) begin
					for (int c = 0; c < 4; c++) begin
						a0 = st[4*c];
						a1 = st[4*c+1];
						a2 = st[4*c+2];
						a3 = st[4*c+3];
						st[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
						st[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
						st[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
						st[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
					end
				end
			end
			key = key_store[r];
			for (int i = 0; i < 16; i++) st[i] ^= key[127-8*i -: 8];
		end
		for (int i = 0; i < 16; i++) result[127-8*i -: 8] = st[i];
		return result;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// response side: compare against the oldest predicted ciphertext
			if (rsp_valid && rsp_ready) begin
				if (cipher_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("unexpected response: high %h low %h",
							rsp.cipher_high, rsp.cipher_low);
				end else begin
					want = cipher_q.pop_front();
					if (rsp.cipher_high !== want[127:64] || rsp.cipher_low !== want[63:0]) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("cipher mismatch: expected high %h low %h, got high %h low %h",
								want[127:64], want[63:0], rsp.cipher_high, rsp.cipher_low);
					end
				end
			end
			// request side: key loads update the store, encrypts queue a ciphertext
			if (req_valid && req_ready) begin
				if (req.opcode == bce_pkg::OP_LOAD) begin
					// slots past the last round key are dropped
					if (req.key_slot <= ROUNDS)
						key_store[req.key_slot] = {req.block_high, req.block_low};
				end else begin
					cipher_q.push_back(predict_cipher({req.block_high, req.block_low}));
				end
			end
			mismatch_count <= errors;
			pending_count  <= cipher_q.size();
		end
	end

endmodule

FILE: sim/block_cipher_encrypt_tb.sv
// Testbench top for the block cipher encrypt core: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module block_cipher_encrypt_tb;

	localparam int ROUNDS       = bce_pkg::ROUNDS_DEF;
	localparam int KEY_SLOTS    = ROUNDS + 1;
	localparam int RANDOM_REQS  = 1530;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 40;
	localparam int DRAIN_CYCLES = 40;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          rsp_ready = 1'b0;
	bce_pkg::req_t req       = '0;
	logic          req_ready;
	logic          rsp_valid;
	bce_pkg::rsp_t rsp;
	int            mismatch_count;
	int            pending_count;
	int            cycle_count   = 0;
	logic          send_burst    = 1'b0;

	block_cipher_encrypt #(
		.ROUNDS(ROUNDS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	block_cipher_encrypt_checker #(
		.ROUNDS(ROUNDS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.mismatch_count(mismatch_count),
		.pending_count (pending_count)
	);

	always #5 clk = ~clk;

	// Run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("block_cipher_encrypt_tb: errors");
			$finish;
		end
	end

	// Half block with extremes mixed into random data
	function automatic logic [bce_pkg::HALF_W-1:0] rand_half();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return {$urandom, $urandom};
			end
		endcase
	endfunction

	// Offer one request after a random gap and hold it until taken
	task automatic send_req(input logic op, input logic [bce_pkg::KEY_SLOT_W-1:0] slot,
		input logic [bce_pkg::HALF_W-1:0] hi, input logic [bce_pkg::HALF_W-1:0] lo);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{op, slot, hi, lo};
		do @(posedge clk); while (!req_ready);
	endtask

	// Response side: random stalls, bursts without stalls, one long hold-off
	initial begin
		int   stall;
		int   rsp_seen;
		logic recv_burst;
		logic held;
		rsp_seen   = 0;
		recv_burst = 1'b0;
		held       = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 13);
			// long hold-off so the core fills up and stalls its request side
			if (!held && rsp_seen == HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			rsp_seen++;
		end
	end

	// Request stimulus and verdict
	initial begin
		int   counted;
		int   pick;
		logic paused;
		counted = 0;
		paused  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every key slot; all ones in the first, zero in the last
		for (int s = 0; s < KEY_SLOTS; s++) begin
			if (s == 0) send_req(bce_pkg::OP_LOAD, 4'(s), '1, '1);
			else if (s == ROUNDS) send_req(bce_pkg::OP_LOAD, 4'(s), '0, '0);
			else send_req(bce_pkg::OP_LOAD, 4'(s), rand_half(), rand_half());
		end
		// loads past the last slot must leave the store alone
		send_req(bce_pkg::OP_LOAD, 4'(KEY_SLOTS), rand_half(), rand_half());
		send_req(bce_pkg::OP_LOAD, 4'hf, '1, '1);
		// plaintext extremes; slot field is don't-care on encrypt
		send_req(bce_pkg::OP_ENCRYPT, 4'h0, '0, '0);
		send_req(bce_pkg::OP_ENCRYPT, 4'hf, '1, '1);
		send_req(bce_pkg::OP_ENCRYPT, 4'h5, {8{8'h80}}, {8{8'h7f}});
		send_req(bce_pkg::OP_ENCRYPT, 4'ha, {16{4'ha}}, {16{4'h5}});
		// swap extremes between the first and last key
		send_req(bce_pkg::OP_LOAD, 4'h0, '0, '0);
		send_req(bce_pkg::OP_ENCRYPT, 4'h3, {$urandom, $urandom}, {$urandom, $urandom});
		send_req(bce_pkg::OP_LOAD, 4'(ROUNDS), '1, '1);
		send_req(bce_pkg::OP_ENCRYPT, 4'hc, '0, '1);

		// random mix: mostly encrypts, key reloads, a few dropped loads
		while (counted < RANDOM_REQS) begin
			if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
			// once, halfway: stop offering until every ciphertext is back
			if (!paused && counted >= RANDOM_REQS / 2) begin
				paused = 1'b1;
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_count != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_req(bce_pkg::OP_ENCRYPT, 4'($urandom_range(0, 15)), rand_half(),
					rand_half());
			end else if (pick < 94) begin
				send_req(bce_pkg::OP_LOAD, 4'($urandom_range(0, ROUNDS)), rand_half(),
					rand_half());
			end else begin
				send_req(bce_pkg::OP_LOAD, 4'($urandom_range(KEY_SLOTS, 15)), rand_half(),
					rand_half());
			end
			counted++;
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("block_cipher_encrypt_tb: clean");
		end else begin
			$display("block_cipher_encrypt_tb: errors");
		end
		$finish;
	end

endmodule
